@@ hdl/gfinv_pkg.sv @@
// ----------------------------------------------------------------------------
// gfinv_pkg
// Shared constants and state types for the GF(2)[x] inversion block.
// ----------------------------------------------------------------------------
`default_nettype none

package gfinv_pkg;

  localparam int ELEM_W      = 16;              // element, inverse and modulus fields
  localparam int WIDTH_DFLT  = 16;              // default working polynomial width
  localparam logic [ELEM_W-1:0] MOD_RESET = 16'h011B;  // x^8+x^4+x^3+x+1

  // divider sequencer
  typedef enum logic [3:0] {
    DV_IDLE = 4'b0001,
    DV_NORM = 4'b0010,
    DV_SCAN = 4'b0100,
    DV_DONE = 4'b1000
  } div_state_t;

  // top-level sequencer
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CHK    = 7'b0000010,
    ST_LOOP   = 7'b0000100,
    ST_COF    = 7'b0001000,
    ST_RSTART = 7'b0010000,
    ST_RES    = 7'b0100000,
    ST_FIN    = 7'b1000000
  } top_state_t;

endpackage

`default_nettype wire

@@ hdl/gfinv_elem_if.sv @@
// ----------------------------------------------------------------------------
// gfinv_elem_if
// Valid/ready channel carrying one polynomial to invert.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfinv_elem_if
  import gfinv_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

`default_nettype wire

@@ hdl/gfinv_res_if.sv @@
// ----------------------------------------------------------------------------
// gfinv_res_if
// Valid/ready channel carrying the inverse and the invertible flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfinv_res_if
  import gfinv_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] inverse;
  logic              invertible;

  modport source (output valid, output inverse, output invertible, input ready);
  modport sink   (input valid, input inverse, input invertible, output ready);
endinterface

`default_nettype wire

@@ hdl/gf2m_inverse_euclid.sv @@
// ----------------------------------------------------------------------------
// gf2m_inverse_euclid
// Inversion in GF(2)[x] modulo a configured polynomial by the extended
// Euclidean algorithm, one divider step per clock.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  in_ch    | in  | valid/ready        | element[15:0]
//  out_ch   | out | valid/ready        | inverse[15:0], invertible
//  cfg_     | in  | cfg_wr_en, no wait | cfg_wr_data[15:0] = modulus
//
//  One item at a time. Each polynomial division first normalizes the divisor
//  one bit a cycle, then scans the dividend one bit a cycle; an item runs up
//  to about WIDTH+2 divisions, fewer for typical operands.
//  Reset (synchronous, rst_n low) loads the modulus 0x11B and idles the block.
//  A finished result waits in the output register; the next item is taken
//  meanwhile and holds at its end until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module gf2m_inverse_euclid
  import gfinv_pkg::*;
#(
  parameter int WIDTH = WIDTH_DFLT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  gfinv_elem_if.sink             in_ch,
  gfinv_res_if.source            out_ch,
  input  wire logic              cfg_wr_en,
  input  wire logic [ELEM_W-1:0] cfg_wr_data
);

  top_state_t        st_r, st_nxt;
  logic [ELEM_W-1:0] mod_r;
  logic [WIDTH-1:0]  d_r, d_nxt;
  logic [WIDTH-1:0]  a_r, a_nxt;
  logic [WIDTH-1:0]  x_r, x_nxt;
  logic [WIDTH-1:0]  s_r, s_nxt;
  logic [WIDTH-1:0]  res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ELEM_W-1:0] out_inv_r, out_inv_nxt;
  logic              out_flag_r, out_flag_nxt;

  logic [WIDTH+ELEM_W-1:0] elem_ext, mod_ext;
  logic [WIDTH+ELEM_W-1:0] res_ext;
  logic [WIDTH-1:0]        elem_w, mod_w;

  logic             div_start, div_done;
  logic [WIDTH-1:0] div_num, div_den, div_acc0, div_mul;
  logic [WIDTH-1:0] div_rem, div_acc;

  // fit the 16-bit fields to the working width
  assign elem_ext = {{WIDTH{1'b0}}, in_ch.element};
  assign mod_ext  = {{WIDTH{1'b0}}, mod_r};
  assign elem_w   = elem_ext[WIDTH-1:0];
  assign mod_w    = mod_ext[WIDTH-1:0];
  assign res_ext  = {{ELEM_W{1'b0}}, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MOD_RESET;
    end else if (cfg_wr_en) begin
      mod_r <= cfg_wr_data;
    end
  end

  gfinv_div #(
    .WIDTH (WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .acc_init (div_acc0),
    .mul      (div_mul),
    .done     (div_done),
    .rem      (div_rem),
    .acc      (div_acc)
  );

  always_comb begin
    st_nxt        = st_r;
    d_nxt         = d_r;
    a_nxt         = a_r;
    x_nxt         = x_r;
    s_nxt         = s_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_inv_nxt   = out_inv_r;
    out_flag_nxt  = out_flag_r;
    div_start     = 1'b0;
    div_num       = d_r;
    div_den       = a_r;
    div_acc0      = x_r;
    div_mul       = s_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          d_nxt  = mod_w;
          a_nxt  = elem_w;
          x_nxt  = '0;
          s_nxt  = {{(WIDTH-1){1'b0}}, 1'b1};
          st_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        div_start = 1'b1;
        if (a_r == '0) begin
          // cofactor n div g: quotient comes out as acc with mul = 1
          div_num  = mod_w;
          div_den  = d_r;
          div_acc0 = '0;
          div_mul  = {{(WIDTH-1){1'b0}}, 1'b1};
          st_nxt   = ST_COF;
        end else begin
          st_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (div_done) begin
          d_nxt  = a_r;
          a_nxt  = div_rem;
          x_nxt  = s_r;
          s_nxt  = div_acc;
          st_nxt = ST_CHK;
        end
      end
      ST_COF: begin
        if (div_done) begin
          a_nxt  = div_acc;
          st_nxt = ST_RSTART;
        end
      end
      ST_RSTART: begin
        div_start = 1'b1;
        div_num   = x_r ^ mod_w;
        div_den   = a_r;
        div_acc0  = '0;
        div_mul   = '0;
        st_nxt    = ST_RES;
      end
      ST_RES: begin
        if (div_done) begin
          res_nxt = div_rem;
          st_nxt  = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free or being drained
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_inv_nxt   = res_ext[ELEM_W-1:0];
          out_flag_nxt  = (d_r == {{(WIDTH-1){1'b0}}, 1'b1});
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r        <= d_nxt;
    a_r        <= a_nxt;
    x_r        <= x_nxt;
    s_r        <= s_nxt;
    res_r      <= res_nxt;
    out_inv_r  <= out_inv_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign in_ch.ready       = (st_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.inverse    = out_inv_r;
  assign out_ch.invertible = out_flag_r;

endmodule

`default_nettype wire

@@ hdl/gfinv_div.sv @@
// ----------------------------------------------------------------------------
// gfinv_div
// Bit-serial polynomial divider over GF(2). Returns the remainder of num by
// den and acc_init XOR (quotient * mul), truncated to WIDTH bits.
// ----------------------------------------------------------------------------
`default_nettype none

module gfinv_div
  import gfinv_pkg::*;
#(
  parameter int WIDTH = WIDTH_DFLT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] num,
  input  wire logic [WIDTH-1:0] den,
  input  wire logic [WIDTH-1:0] acc_init,
  input  wire logic [WIDTH-1:0] mul,
  output logic                  done,
  output logic      [WIDTH-1:0] rem,
  output logic      [WIDTH-1:0] acc
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  div_state_t         st_r, st_nxt;
  logic [WIDTH-1:0]   num_r, num_nxt;
  logic [WIDTH-1:0]   den_r, den_nxt;
  logic [2*WIDTH-1:0] ms_r, ms_nxt;      // mul shifted along with den
  logic [WIDTH-1:0]   acc_r, acc_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;    // current shift of den
  logic [CW-1:0]      pos_r, pos_nxt;    // bit of num under test

  always_comb begin
    st_nxt  = st_r;
    num_nxt = num_r;
    den_nxt = den_r;
    ms_nxt  = ms_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    unique case (st_r)
      DV_IDLE: begin
        if (start) begin
          num_nxt = num;
          den_nxt = den;
          ms_nxt  = {{WIDTH{1'b0}}, mul};
          acc_nxt = acc_init;
          cnt_nxt = '0;
          // zero divisor: quotient 0, remainder is the dividend
          st_nxt  = (den == '0) ? DV_DONE : DV_NORM;
        end
      end
      DV_NORM: begin
        // shift den up until its leading term sits in the top bit
        if (den_r[WIDTH-1]) begin
          pos_nxt = CW'(WIDTH - 1);
          st_nxt  = DV_SCAN;
        end else begin
          den_nxt = {den_r[WIDTH-2:0], 1'b0};
          ms_nxt  = {ms_r[2*WIDTH-2:0], 1'b0};
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      DV_SCAN: begin
        if (num_r[pos_r]) begin
          num_nxt = num_r ^ den_r;
          acc_nxt = acc_r ^ ms_r[WIDTH-1:0];
        end
        if (cnt_r == '0) begin
          st_nxt = DV_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
          pos_nxt = pos_r - 1'b1;
          den_nxt = {1'b0, den_r[WIDTH-1:1]};
          ms_nxt  = {1'b0, ms_r[2*WIDTH-1:1]};
        end
      end
      DV_DONE: begin
        st_nxt = DV_IDLE;
      end
      default: begin
        st_nxt = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= DV_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    ms_r  <= ms_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    pos_r <= pos_nxt;
  end

  assign done = (st_r == DV_DONE);
  assign rem  = num_r;
  assign acc  = acc_r;

endmodule

`default_nettype wire
